// ===== rtl/video_slice_drop_filter_macros.svh =====
// Assertion macros shared by the video slice drop filter RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef VIDEO_SLICE_DROP_FILTER_MACROS_SVH
`define VIDEO_SLICE_DROP_FILTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VSDF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vsdf assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define VSDF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vsdf assertion failed");

`endif

// ===== rtl/vsdf_pkg.sv =====
// Types, constants and register codes of the video slice drop filter.
// Depends on nothing; imported by every RTL module of the block.
package vsdf_pkg;

  localparam int unsigned STRIPS_DEF  = 50;
  localparam int unsigned CAMERAS_DEF = 200;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Register reset values
  localparam logic [31:0] VIDEO_DEST_IP_RST   = 32'h0A01_0102;
  localparam logic [15:0] VIDEO_BASE_PORT_RST = 16'd5000;
  localparam logic [15:0] ROBOT_PORT_RST      = 16'd5555;
  localparam logic [9:0]  VIEW_WIDTH_RST      = 10'd20;
  localparam logic [15:0] COORD_LIMIT_RST     = 16'd1000;

  // Header constants
  localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  IP_PROTO_UDP  = 8'd17;
  localparam logic [5:0]  NAL_TYPE_FU   = 6'd49;
  localparam logic [5:0]  NAL_SLICE_LO  = 6'd1;
  localparam logic [5:0]  NAL_SLICE_HI  = 6'd9;
  localparam logic [1:0]  RTP_VERSION_2 = 2'd2;
  localparam logic [7:0]  ETH_HDR_LEN   = 8'd14;

  // Frame length needed for each part; all but MIN_FRAME_LEN are counted from the UDP header
  localparam logic [13:0] MIN_FRAME_LEN = 14'd34;
  localparam logic [13:0] UDP_HDR_END   = 14'd8;
  localparam logic [13:0] POSITION_END  = 14'd16;
  localparam logic [13:0] RTP_HDR_END   = 14'd20;
  localparam logic [13:0] PAYLOAD_END   = 14'd22;
  localparam logic [13:0] FU_HDR_END    = 14'd23;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VIDEO_DEST_IP   = 3'd0,
    CFG_VIDEO_BASE_PORT = 3'd1,
    CFG_ROBOT_PORT      = 3'd2,
    CFG_VIEW_WIDTH      = 3'd3,
    CFG_COORD_LIMIT     = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CLS_OTHER       = 2'd0,
    CLS_POS_APPLIED = 2'd1,
    CLS_POS_IGNORED = 2'd2,
    CLS_VIDEO       = 2'd3
  } pkt_class_e;

  typedef struct packed {
    logic [31:0] video_dest_ip;
    logic [15:0] video_base_port;
    logic [15:0] robot_port;
    logic [9:0]  view_width;
    logic [15:0] coord_limit;
  } cfg_t;

  typedef struct packed {
    logic [15:0] robot_x;
    logic [15:0] robot_y;
    logic        position_known;
  } pos_t;

  typedef struct packed {
    logic [13:0] frame_length;
    logic [15:0] ether_type;
    logic [3:0]  ip_header_words;
    logic [7:0]  ip_protocol;
    logic [31:0] ip_dest;
    logic [15:0] udp_dest_port;
    logic [31:0] after_udp_word0;
    logic [31:0] after_udp_word1;
    logic [7:0]  payload_byte0;
    logic [7:0]  fu_byte;
  } in_item_t;

  typedef struct packed {
    logic       verdict;
    logic [1:0] packet_class;
    logic [7:0] camera_index;
    logic       drop_mode;
  } out_item_t;

endpackage

// ===== rtl/vsdf_stream_if.sv =====
// Valid/ready stream channel carrying one payload item per handshake.
// Depends on nothing; the payload type is set per instance.
interface vsdf_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/video_slice_drop_filter.sv =====
// Video slice drop filter: one pass/drop verdict per packet header summary.
// Two register stages: an input register feeds the decision logic, whose verdict
// goes to a result register. Takes one item per cycle while the output is ready;
// the two registers decouple the sides, and the decision logic is combinational.
// Reset: clears the valid flags, the stored position, the FU open flag, and
// loads the configuration registers with their defaults.
module video_slice_drop_filter
  import vsdf_pkg::*;
#(
  parameter int unsigned STRIPS  = STRIPS_DEF,
  parameter int unsigned CAMERAS = CAMERAS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  vsdf_stream_if.sink           in_i,
  vsdf_stream_if.source         out_o
);

  cfg_t     cfg;
  logic     in_valid_q;
  in_item_t in_item_q;
  logic     core_ready;

  vsdf_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  // input register advances whenever the decision stage takes its item
  assign in_i.ready = !in_valid_q || core_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_item_q <= in_i.payload;
    end
  end

  vsdf_core #(
    .STRIPS (STRIPS),
    .CAMERAS(CAMERAS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .valid_i    (in_valid_q),
    .item_i     (in_item_q),
    .ready_o    (core_ready),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .out_item_o (out_o.payload)
  );

endmodule

// ===== rtl/vsdf_cfg_regs.sv =====
// Configuration register file of the video slice drop filter.
// Depends on vsdf_pkg.
module vsdf_cfg_regs
  import vsdf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_VIDEO_DEST_IP:   cfg_d.video_dest_ip   = cfg_wdata_i;
        CFG_VIDEO_BASE_PORT: cfg_d.video_base_port = cfg_wdata_i[15:0];
        CFG_ROBOT_PORT:      cfg_d.robot_port      = cfg_wdata_i[15:0];
        CFG_VIEW_WIDTH:      cfg_d.view_width      = cfg_wdata_i[9:0];
        CFG_COORD_LIMIT:     cfg_d.coord_limit     = cfg_wdata_i[15:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.video_dest_ip   <= VIDEO_DEST_IP_RST;
      cfg_q.video_base_port <= VIDEO_BASE_PORT_RST;
      cfg_q.robot_port      <= ROBOT_PORT_RST;
      cfg_q.view_width      <= VIEW_WIDTH_RST;
      cfg_q.coord_limit     <= COORD_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/vsdf_cam_mode.sv =====
// Camera mode lookup: strip test of the stored robot position for one camera.
// Depends on vsdf_pkg.
module vsdf_cam_mode
  import vsdf_pkg::*;
#(
  parameter int unsigned STRIPS = STRIPS_DEF
) (
  input  logic [7:0] cam_i,
  input  pos_t       pos_i,
  input  logic [9:0] view_width_i,
  output logic       mode_o
);

  localparam int unsigned IDX_W  = $clog2(STRIPS + 1);
  localparam int unsigned PROD_W = IDX_W + 10;
  localparam int unsigned CMP_W  = (PROD_W + 1 > 16) ? PROD_W + 1 : 16;

  logic             strip_cam;
  logic             y_strip;
  logic [IDX_W-1:0] idx;
  logic [15:0]      coord;
  logic [CMP_W-1:0] lo;
  logic [CMP_W-1:0] hi;
  logic [CMP_W-1:0] coord_ext;

  always_comb begin
    strip_cam = {1'b0, cam_i} < 9'(2 * STRIPS);
    y_strip   = {1'b0, cam_i} < 9'(STRIPS);
    // cameras of the upper half test x against strip cam - STRIPS
    idx   = y_strip ? IDX_W'(cam_i) : IDX_W'({1'b0, cam_i} - 9'(STRIPS));
    coord = y_strip ? pos_i.robot_y : pos_i.robot_x;
    lo    = CMP_W'(PROD_W'(idx) * PROD_W'(view_width_i));
    hi    = lo + CMP_W'(view_width_i);
    coord_ext = CMP_W'(coord);
    mode_o = pos_i.position_known && strip_cam && !(coord_ext >= lo && coord_ext < hi);
  end

endmodule

// ===== rtl/vsdf_core.sv =====
// Decision stage: header checks, position and FU tracking state, result register.
// Depends on vsdf_pkg, vsdf_cam_mode and video_slice_drop_filter_macros.svh.
`include "video_slice_drop_filter_macros.svh"

module vsdf_core
  import vsdf_pkg::*;
#(
  parameter int unsigned STRIPS  = STRIPS_DEF,
  parameter int unsigned CAMERAS = CAMERAS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      valid_i,
  input  in_item_t  item_i,
  output logic      ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  pos_t      pos_q, pos_d;
  logic      p_open_q, p_open_d;
  logic      out_valid_q;
  out_item_t res_q, res_d;

  logic        fire;
  logic [7:0]  udp_off;
  logic [13:0] flen;
  logic [13:0] udp_off_ext;
  logic        hdr_ok;
  logic        robot_hit;
  logic        pos_ok;
  logic        video_hit;
  logic [7:0]  cam;
  logic        mode;
  logic        rtp_ok;
  logic [5:0]  nal;
  logic [5:0]  fu_type;
  logic        p_start;
  logic        p_open_eff;

  assign ready_o = !out_valid_q || out_ready_i;
  assign fire    = valid_i && ready_o;

  vsdf_cam_mode #(
    .STRIPS(STRIPS)
  ) u_cam_mode (
    .cam_i       (cam),
    .pos_i       (pos_q),
    .view_width_i(cfg_i.view_width),
    .mode_o      (mode)
  );

  always_comb begin
    flen        = item_i.frame_length;
    udp_off     = 8'({item_i.ip_header_words, 2'b00}) + ETH_HDR_LEN;
    udp_off_ext = 14'(udp_off);

    hdr_ok = flen >= MIN_FRAME_LEN && item_i.ether_type == ETH_TYPE_IPV4 &&
             item_i.ip_protocol == IP_PROTO_UDP && flen >= udp_off_ext + UDP_HDR_END;

    robot_hit = hdr_ok && item_i.udp_dest_port == cfg_i.robot_port;
    pos_ok    = flen >= udp_off_ext + POSITION_END &&
                item_i.after_udp_word0 < 32'(cfg_i.coord_limit) &&
                item_i.after_udp_word1 < 32'(cfg_i.coord_limit);

    // camera range without wrap
    video_hit = hdr_ok && !robot_hit && item_i.ip_dest == cfg_i.video_dest_ip &&
                item_i.udp_dest_port >= cfg_i.video_base_port &&
                {1'b0, item_i.udp_dest_port} <
                  ({1'b0, cfg_i.video_base_port} + 17'(CAMERAS));
    cam = 8'(item_i.udp_dest_port - cfg_i.video_base_port);

    rtp_ok = flen >= udp_off_ext + RTP_HDR_END &&
             item_i.after_udp_word0[31:30] == RTP_VERSION_2 && mode &&
             flen >= udp_off_ext + PAYLOAD_END;

    nal        = item_i.payload_byte0[6:1];
    fu_type    = item_i.fu_byte[5:0];
    p_start    = item_i.fu_byte[7] && (fu_type inside {[NAL_SLICE_LO:NAL_SLICE_HI]});
    p_open_eff = p_open_q || p_start;

    pos_d    = pos_q;
    p_open_d = p_open_q;
    res_d    = '0;
    res_d.packet_class = CLS_OTHER;

    if (robot_hit) begin
      res_d.packet_class = CLS_POS_IGNORED;
      if (pos_ok) begin
        res_d.packet_class   = CLS_POS_APPLIED;
        pos_d.robot_x        = item_i.after_udp_word0[15:0];
        pos_d.robot_y        = item_i.after_udp_word1[15:0];
        pos_d.position_known = 1'b1;
      end
    end else if (video_hit) begin
      res_d.packet_class = CLS_VIDEO;
      res_d.camera_index = cam;
      res_d.drop_mode    = mode;
      if (rtp_ok) begin
        if (nal == NAL_TYPE_FU) begin
          // a short FU header leaves the open flag alone
          if (flen >= udp_off_ext + FU_HDR_END) begin
            res_d.verdict = p_open_eff;
            p_open_d      = p_open_eff && !item_i.fu_byte[6];
          end
        end else begin
          res_d.verdict = nal inside {[NAL_SLICE_LO:NAL_SLICE_HI]};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      p_open_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        pos_q    <= pos_d;
        p_open_q <= p_open_d;
      end
      if (ready_o) begin
        out_valid_q <= valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = res_q;

  `VSDF_ASSERT_IMP(a_pass_non_video, clk_i, rst_ni,
                   out_valid_q && res_q.packet_class != CLS_VIDEO, !res_q.verdict)
  `VSDF_ASSERT_IMP(a_drop_needs_mode, clk_i, rst_ni,
                   out_valid_q && res_q.verdict, res_q.drop_mode)
  `VSDF_ASSERT_NXT(a_pos_stored, clk_i, rst_ni,
                   fire && res_d.packet_class == CLS_POS_APPLIED, pos_q.position_known)
  `VSDF_ASSERT_NXT(a_state_holds, clk_i, rst_ni,
                   !fire, $stable(p_open_q) && $stable(pos_q))

endmodule
